// ----- sv/leaky_lms_adaptive_filter_assert.svh -----
// Assertion macros for the leaky LMS filter checker.
// Expects clk and rst to be visible in the scope of each use.
`ifndef LEAKY_LMS_ADAPTIVE_FILTER_ASSERT_SVH
`define LEAKY_LMS_ADAPTIVE_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LLMS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LLMS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/llms_pkg.sv -----
// Shared types and fixed-point constants of the leaky LMS filter.
// No dependencies; imported by the top level and the multiplier.
`default_nettype none

package llms_pkg;

  // Weight format: signed Q4.28
  localparam int W_W        = 32;
  localparam int W_FRAC     = 28;
  // Configuration registers
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int LEAK_SHIFT = 23;
  localparam int STEP_SHIFT = 20;
  // Shared multiplier: 33 x 33 signed
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  // Split point of the mu*error product for the two-part step multiply
  localparam int Q_SPLIT    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAKAGE   = 2'd1;

  localparam logic [CFG_W-1:0] STEP_RESET = 24'd256;
  localparam logic [CFG_W-1:0] LEAK_RESET = 24'd8387769;

  localparam logic [W_W-1:0] W_MAX = 32'h7fff_ffff;
  localparam logic [W_W-1:0] W_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_ERR,
    S_QMUL,
    S_QSAVE,
    S_LEAK,
    S_LO,
    S_HI,
    S_WRITE,
    S_DONE
  } llms_state_t;

endpackage

`default_nettype wire

// ----- sv/llms_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module llms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/llms_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on llms_pkg for operand and product widths.
`default_nettype none

module llms_mul import llms_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  a,
  input  wire logic signed [MUL_W-1:0]  b,
  output logic      signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

// ----- sv/leaky_lms_adaptive_filter.sv -----
// Top level of the leaky LMS adaptive FIR filter: sequencer, datapath, stores.
// Depends on llms_pkg, llms_ram and llms_mul.
`default_nettype none

// Leaky LMS adaptive FIR filter. Each accepted word carries one signed sample
// (tlast is a block marker that is only passed along). The sample enters a
// circular delay line of TAPS entries; the estimate y is the sum of the Q4.28
// weights times the newest TAPS samples, the current one included, and the
// output word carries error = sample - y, floored and saturated to
// SAMPLE_WIDTH bits. Each weight then becomes
// floor(leakage*w/2^23) + floor(step_size*error*tap/2^20), saturated to 32
// bits; leakage is Q1.23 and step_size scales by 2^-48. All arithmetic runs
// through one 33x33 signed multiplier under a small sequencer, so a new word
// is taken only once the last one is through all of its steps. In order: the
// accepting cycle, a pipelined multiply-accumulate pass, S_ERR, S_QMUL and
// S_QSAVE to form the error and mu*error, per tap the update (leak product,
// two halves of the step product, write-back), and a last step that loads
// the output register and raises m_tvalid. That last step holds while the
// output register is still full and stalled.
// s_tready is high only while idle; the result sits in an output register so
// the next word is taken while it waits. After reset the delay line reads as
// zero through a fill count and the weights through a flag set by the first
// update pass, so no clearing pass is needed. Configuration writes are taken
// at any cycle with cfg_we high; indexes other than 0 and 1 are dropped.

module leaky_lms_adaptive_filter import llms_pkg::*; #(
  parameter int TAPS         = 32,
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  // input stream; tdata: sample [SAMPLE_WIDTH-1:0], zero padding above
  input  wire logic                                      s_tvalid,
  output logic                                           s_tready,
  input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  input  wire logic                                      s_tlast,
  // output stream; tdata: error_out [SAMPLE_WIDTH-1:0], zero padding above
  output logic                                           m_tvalid,
  input  wire logic                                      m_tready,
  output logic      [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
  output logic                                           m_tlast,
  // configuration write port
  input  wire logic                                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]                      cfg_index,
  input  wire logic [CFG_W-1:0]                          cfg_data
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int AW      = $clog2(TAPS);
  localparam int FILL_W  = AW + 1;
  localparam int TDATA_W = ((SW + 7) / 8) * 8;
  // Exact accumulator of TAPS weight*sample products
  localparam int ACC_W   = W_W + SW + AW;
  localparam int DIFF_W  = ACC_W + 1;
  localparam int EF_W    = DIFF_W - W_FRAC;
  // mu*error and its split
  localparam int Q_W     = CFG_W + SW + 1;
  localparam int QH_W    = Q_W - Q_SPLIT;
  // Update terms
  localparam int LEAK_W  = CFG_W + 1 + W_W - LEAK_SHIFT;
  localparam int LO_W    = MUL_W + SW;
  localparam int LOS_W   = LO_W - STEP_SHIFT;
  localparam int PART_W  = ((LEAK_W > LOS_W) ? LEAK_W : LOS_W) + 1;
  localparam int HI_W    = QH_W + SW;
  localparam int HIS_W   = HI_W + Q_SPLIT - STEP_SHIFT;
  localparam int SUM_W   = ((PART_W > HIS_W) ? PART_W : HIS_W) + 1;

  localparam logic [AW-1:0]     LAST_K = AW'(TAPS - 1);
  localparam logic [FILL_W-1:0] FULL   = FILL_W'(TAPS);
  localparam logic [SW-1:0]     S_MAX  = {1'b0, {(SW - 1){1'b1}}};
  localparam logic [SW-1:0]     S_MIN  = {1'b1, {(SW - 1){1'b0}}};

  llms_state_t state, state_next;

  // Control
  logic [CFG_W-1:0]  step_size;
  logic [CFG_W-1:0]  leakage;
  logic [AW-1:0]     wp;
  logic [FILL_W-1:0] fill;
  logic              w_live;
  logic              issue_on;
  logic              rd_v;
  logic              mul_v;
  logic              out_valid;
  logic [AW-1:0]     k;
  logic [AW-1:0]     idx;
  logic              dl_live;

  // Payload
  logic signed [SW-1:0]     x_reg;
  logic                     last_reg;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SW-1:0]     err;
  logic signed [Q_W-1:0]    q;
  logic signed [SW-1:0]     tap_cur;
  logic signed [LEAK_W-1:0] leak;
  logic signed [PART_W-1:0] part;
  logic [SW-1:0]            out_err;
  logic                     out_last;

  // Stores and multiplier
  logic              dl_we;
  logic [AW-1:0]     dl_raddr;
  logic [SW-1:0]     dl_rdata;
  logic              w_we;
  logic [AW-1:0]     w_raddr;
  logic [W_W-1:0]    w_rdata;
  logic [W_W-1:0]    w_wdata;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  // Datapath wires
  logic                     accept;
  logic                     out_free;
  logic                     load_out;
  logic [AW-1:0]            k_inc;
  logic [AW-1:0]            idx_dec;
  logic [AW-1:0]            wp_inc;
  logic signed [SW-1:0]     tap_rd;
  logic signed [W_W-1:0]    w_rd;
  logic signed [W_W+SW-1:0] prod_mac;
  logic signed [DIFF_W-1:0] diff;
  logic signed [EF_W-1:0]   e_full;
  logic signed [SW-1:0]     e_sat;
  logic signed [LEAK_W-1:0] leak_new;
  logic signed [LOS_W-1:0]  lo_s;
  logic signed [HIS_W-1:0]  hi_s;
  logic signed [SUM_W-1:0]  sum;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign load_out = (state == S_DONE) && out_free;

  assign k_inc   = (k == LAST_K) ? '0 : k + 1'b1;
  assign idx_dec = (idx == '0) ? LAST_K : idx - 1'b1;
  assign wp_inc  = (wp == LAST_K) ? '0 : wp + 1'b1;

  // Entries past the fill count and weights before the first update read as 0
  assign tap_rd   = dl_live ? $signed(dl_rdata) : '0;
  assign w_rd     = w_live ? $signed(w_rdata) : '0;
  assign prod_mac = prod[W_W+SW-1:0];

  // error = floor((x*2^28 - acc) / 2^28), saturated to the sample width
  assign diff   = (DIFF_W'(x_reg) <<< W_FRAC) - DIFF_W'(acc);
  assign e_full = diff[DIFF_W-1:W_FRAC];
  always_comb begin
    if ((&e_full[EF_W-1:SW-1]) || !(|e_full[EF_W-1:SW-1])) begin
      e_sat = e_full[SW-1:0];
    end else if (e_full[EF_W-1]) begin
      e_sat = S_MIN;
    end else begin
      e_sat = S_MAX;
    end
  end

  // Update terms, each taken from the product register of its own cycle
  assign leak_new = prod[LEAK_SHIFT+LEAK_W-1:LEAK_SHIFT];
  assign lo_s     = prod[STEP_SHIFT+LOS_W-1:STEP_SHIFT];
  assign hi_s     = {prod[HI_W-1:0], {(Q_SPLIT - STEP_SHIFT){1'b0}}};
  assign sum      = SUM_W'(part) + SUM_W'(hi_s);

  always_comb begin
    if ((&sum[SUM_W-1:W_W-1]) || !(|sum[SUM_W-1:W_W-1])) begin
      w_wdata = sum[W_W-1:0];
    end else if (sum[SUM_W-1]) begin
      w_wdata = W_MIN;
    end else begin
      w_wdata = W_MAX;
    end
  end

  llms_ram #(
    .WIDTH (SW),
    .DEPTH (TAPS)
  ) u_delay (
    .clk   (clk),
    .we    (dl_we),
    .waddr (wp),
    .wdata (s_tdata[SW-1:0]),
    .raddr (dl_raddr),
    .rdata (dl_rdata)
  );

  llms_ram #(
    .WIDTH (W_W),
    .DEPTH (TAPS)
  ) u_weights (
    .clk   (clk),
    .we    (w_we),
    .waddr (k),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  llms_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake, store addresses and multiplier operands
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    dl_we      = accept;
    w_we       = 1'b0;
    dl_raddr   = idx;
    w_raddr    = k;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        // read issue -> multiply -> accumulate, one tap per cycle
        mul_a = {w_rd[W_W-1], w_rd};
        mul_b = {{(MUL_W - SW){tap_rd[SW-1]}}, tap_rd};
        if (!issue_on && !rd_v && !mul_v) begin
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        state_next = S_QMUL;
      end
      S_QMUL: begin
        mul_a      = {{(MUL_W - CFG_W){1'b0}}, step_size};
        mul_b      = {{(MUL_W - SW){err[SW-1]}}, err};
        state_next = S_QSAVE;
      end
      S_QSAVE: begin
        state_next = S_LEAK;
      end
      S_LEAK: begin
        mul_a      = {{(MUL_W - CFG_W){1'b0}}, leakage};
        mul_b      = {w_rd[W_W-1], w_rd};
        state_next = S_LO;
      end
      S_LO: begin
        mul_a      = {1'b0, q[Q_SPLIT-1:0]};
        mul_b      = {{(MUL_W - SW){tap_cur[SW-1]}}, tap_cur};
        state_next = S_HI;
      end
      S_HI: begin
        mul_a      = {{(MUL_W - QH_W){q[Q_W-1]}}, q[Q_W-1:Q_SPLIT]};
        mul_b      = {{(MUL_W - SW){tap_cur[SW-1]}}, tap_cur};
        state_next = S_WRITE;
      end
      S_WRITE: begin
        // write back this tap and fetch the next one
        w_we       = 1'b1;
        dl_raddr   = idx_dec;
        w_raddr    = k_inc;
        state_next = (k == LAST_K) ? S_DONE : S_LEAK;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= STEP_RESET;
      leakage   <= LEAK_RESET;
      wp        <= '0;
      fill      <= '0;
      w_live    <= 1'b0;
      issue_on  <= 1'b0;
      rd_v      <= 1'b0;
      mul_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STEP_SIZE: step_size <= cfg_data;
          REG_LEAKAGE:   leakage   <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        issue_on <= 1'b1;
        if (fill != FULL) begin
          fill <= fill + 1'b1;
        end
      end else if ((state == S_MAC) && issue_on && (k == LAST_K)) begin
        issue_on <= 1'b0;
      end
      rd_v  <= (state == S_MAC) && issue_on;
      mul_v <= (state == S_MAC) && rd_v;
      if ((state == S_WRITE) && (k == LAST_K)) begin
        w_live <= 1'b1;
      end
      if (load_out) begin
        wp        <= wp_inc;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dl_live <= ({1'b0, dl_raddr} < fill);
    if (accept) begin
      x_reg    <= s_tdata[SW-1:0];
      last_reg <= s_tlast;
      acc      <= '0;
      k        <= '0;
      idx      <= wp;
    end
    unique case (state)
      S_MAC: begin
        if (issue_on) begin
          k   <= k_inc;
          idx <= idx_dec;
        end
        if (mul_v) begin
          acc <= acc + ACC_W'(prod_mac);
        end
      end
      S_ERR: begin
        err <= e_sat;
        k   <= '0;
        idx <= wp;
      end
      S_QSAVE: q       <= prod[Q_W-1:0];
      S_LEAK:  tap_cur <= tap_rd;
      S_LO:    leak    <= leak_new;
      S_HI:    part    <= PART_W'(leak) + PART_W'(lo_s);
      S_WRITE: begin
        k   <= k_inc;
        idx <= idx_dec;
      end
      S_IDLE, S_QMUL, S_DONE: ;
      default: ;
    endcase
    if (load_out) begin
      out_err  <= err;
      out_last <= last_reg;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_W'(out_err);
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

// ----- sv/llms_check.sv -----
// Port-level checker for the leaky LMS filter, bound to the top level.
// Depends on leaky_lms_adaptive_filter_assert.svh for the assertion macros.
`default_nettype none

`include "leaky_lms_adaptive_filter_assert.svh"

module llms_check #(
  parameter int DATA_W = 24
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_tvalid,
  input wire logic              s_tready,
  input wire logic              m_tvalid,
  input wire logic              m_tready,
  input wire logic [DATA_W-1:0] m_tdata,
  input wire logic              m_tlast
);

  // words taken in minus words handed out
  logic [1:0] owed;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else begin
      owed <= owed + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
    end
  end

  `LLMS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
                    "input still ready right after a word was taken")
  `LLMS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tlast),
                    "stalled output word changed or dropped")
  `LLMS_ASSERT_IMPL(a_out_owed, m_tvalid, owed != 2'd0,
                    "output word shown with no input word behind it")
  `LLMS_ASSERT_IMPL(a_two_owed_stall, owed == 2'd2, !s_tready,
                    "input ready while two words are still owed")

endmodule

bind leaky_lms_adaptive_filter llms_check #(.DATA_W(TDATA_W)) u_llms_check (.*);

`default_nettype wire
